[sv/i2crm_pkg.sv]
// shared types and constants of the i2c register master
package i2crm_pkg;

    localparam int MAX_BURST     = 256;
    localparam int BITS_PER_BYTE = 8;

    localparam logic [8:0] BURST_MAX_VAL = 9'(MAX_BURST);
    localparam logic [3:0] BYTE_BITS     = 4'(BITS_PER_BYTE);

    // command codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // configuration register indexes
    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_PHASE_TICKS    = 1'b1;

    // bus phases; each phase but idle lasts phase_ticks ticks, with zero acting as one
    typedef enum logic [3:0] {
        PH_IDLE, PH_START_A, PH_START_B, PH_START_C,
        PH_TX_LOW, PH_TX_HIGH, PH_ACK_LOW, PH_ACK_HIGH,
        PH_RX_LOW, PH_RX_HIGH, PH_MACK_LOW, PH_MACK_HIGH,
        PH_STOP_A, PH_STOP_B, PH_STOP_C
    } phase_t;

    // byte stages of a transaction
    typedef enum logic [2:0] {
        ST_ADDR_W, ST_REG, ST_DATA, ST_MID_STOP, ST_ADDR_R, ST_RECV, ST_END_STOP
    } stage_t;

    // sequencer state
    typedef struct packed {
        phase_t      phase;
        stage_t      stage;
        logic [15:0] tick_count;
        logic [3:0]  bit_index;
        logic [7:0]  shift;
        logic [8:0]  bytes_left;
        logic [7:0]  held_reg;
        logic [7:0]  held_data;
        logic        is_read;
        logic        nack_flag;
    } seq_state_t;

    // one result word
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       byte_valid;
        logic [7:0] read_byte;
        logic       last_byte;
        logic       nack_seen;
        logic       busy_res;
        logic       done_res;
    } result_t;

endpackage

[sv/i2crm_if.sv]
// command and result channel interfaces
interface i2crm_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [8:0] read_count;
    logic       sda_in;

    modport source (output valid, op, reg_addr, write_data, read_count, sda_in,
                    input ready);
    modport sink   (input valid, op, reg_addr, write_data, read_count, sda_in,
                    output ready);
endinterface

interface i2crm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       last_byte;
    logic       nack_seen;
    logic       busy_res;
    logic       done_res;

    modport source (output valid, scl_out, sda_out, byte_valid, read_byte, last_byte,
                    nack_seen, busy_res, done_res, input ready);
    modport sink   (input valid, scl_out, sda_out, byte_valid, read_byte, last_byte,
                    nack_seen, busy_res, done_res, output ready);
endinterface

[sv/i2crm_step.sv]
// next state and result of the bit-phase sequencer for one tick
module i2crm_step (
    input  i2crm_pkg::seq_state_t st,
    input  logic [6:0]            device_address,
    input  logic [15:0]           phase_ticks,
    input  logic [1:0]            op,
    input  logic [7:0]            reg_addr,
    input  logic [7:0]            write_data,
    input  logic [8:0]            read_count,
    input  logic                  sda_in,
    output i2crm_pkg::seq_state_t st_next,
    output i2crm_pkg::result_t    res
);
    import i2crm_pkg::*;

    seq_state_t  s;
    logic [15:0] len;
    logic [15:0] tick_inc;
    logic        phase_end;
    logic        txb;
    logic        mack;
    logic [8:0]  cnt;
    logic [3:0]  bit_inc;
    logic [7:0]  rx_shift;
    logic [8:0]  left_dec;

    always_comb
    begin
        s        = st;
        res      = '0;
        res.scl_out = 1'b1;
        res.sda_out = 1'b1;
        len      = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;

        // command start from idle
        cnt = read_count;
        if (cnt == 9'd0)
        begin
            cnt = 9'd1;
        end
        if (cnt > BURST_MAX_VAL)
        begin
            cnt = BURST_MAX_VAL;
        end
        if (st.phase == PH_IDLE && (op == OP_WRITE || op == OP_READ))
        begin
            s.held_reg   = reg_addr;
            s.held_data  = write_data;
            s.bytes_left = cnt;
            s.is_read    = (op == OP_READ);
            s.nack_flag  = 1'b0;
            s.stage      = ST_ADDR_W;
            s.phase      = PH_START_A;
            s.tick_count = 16'd0;
        end

        txb       = s.shift[7];
        mack      = (s.bytes_left == 9'd1);
        tick_inc  = s.tick_count + 16'd1;
        phase_end = (tick_inc >= len) || (tick_inc == 16'd0);
        bit_inc   = s.bit_index + 4'd1;
        rx_shift  = {s.shift[6:0], sda_in};
        left_dec  = (s.bytes_left != 9'd0) ? s.bytes_left - 9'd1 : s.bytes_left;

        if (s.phase != PH_IDLE)
        begin
            res.busy_res = 1'b1;

            // drive levels of the phase
            case (s.phase)
                PH_START_A:   begin res.scl_out = 1'b1; res.sda_out = 1'b1; end
                PH_START_B:   begin res.scl_out = 1'b1; res.sda_out = 1'b0; end
                PH_START_C:   begin res.scl_out = 1'b0; res.sda_out = 1'b0; end
                PH_TX_LOW:    begin res.scl_out = 1'b0; res.sda_out = txb;  end
                PH_TX_HIGH:   begin res.scl_out = 1'b1; res.sda_out = txb;  end
                PH_ACK_LOW,
                PH_RX_LOW:    begin res.scl_out = 1'b0; res.sda_out = 1'b1; end
                PH_ACK_HIGH,
                PH_RX_HIGH:   begin res.scl_out = 1'b1; res.sda_out = 1'b1; end
                PH_MACK_LOW:  begin res.scl_out = 1'b0; res.sda_out = mack; end
                PH_MACK_HIGH: begin res.scl_out = 1'b1; res.sda_out = mack; end
                PH_STOP_A:    begin res.scl_out = 1'b0; res.sda_out = 1'b0; end
                PH_STOP_B:    begin res.scl_out = 1'b1; res.sda_out = 1'b0; end
                default:      begin res.scl_out = 1'b1; res.sda_out = 1'b1; end
            endcase

            s.tick_count = tick_inc;

            // phase transitions at the end of a phase
            if (phase_end)
            begin
                s.tick_count = 16'd0;
                case (s.phase)
                    PH_START_A: s.phase = PH_START_B;
                    PH_START_B: s.phase = PH_START_C;
                    PH_START_C:
                    begin
                        s.bit_index = 4'd0;
                        s.phase     = PH_TX_LOW;
                        if (s.stage == ST_ADDR_R)
                        begin
                            s.shift = {device_address, 1'b1};
                        end
                        else
                        begin
                            s.stage = ST_ADDR_W;
                            s.shift = {device_address, 1'b0};
                        end
                    end
                    PH_TX_LOW: s.phase = PH_TX_HIGH;
                    PH_TX_HIGH:
                    begin
                        s.shift     = {s.shift[6:0], 1'b0};
                        s.bit_index = bit_inc;
                        s.phase     = (bit_inc >= BYTE_BITS) ? PH_ACK_LOW : PH_TX_LOW;
                    end
                    PH_ACK_LOW: s.phase = PH_ACK_HIGH;
                    PH_ACK_HIGH:
                    begin
                        if (sda_in)
                        begin
                            s.nack_flag = 1'b1;
                        end
                        case (s.stage)
                            ST_ADDR_W:
                            begin
                                s.stage     = ST_REG;
                                s.shift     = s.held_reg;
                                s.bit_index = 4'd0;
                                s.phase     = PH_TX_LOW;
                            end
                            ST_REG:
                            begin
                                if (s.is_read)
                                begin
                                    s.stage = ST_MID_STOP;
                                    s.phase = PH_STOP_A;
                                end
                                else
                                begin
                                    s.stage     = ST_DATA;
                                    s.shift     = s.held_data;
                                    s.bit_index = 4'd0;
                                    s.phase     = PH_TX_LOW;
                                end
                            end
                            ST_ADDR_R:
                            begin
                                s.stage     = ST_RECV;
                                s.shift     = 8'd0;
                                s.bit_index = 4'd0;
                                s.phase     = PH_RX_LOW;
                            end
                            default:
                            begin
                                s.stage = ST_END_STOP;
                                s.phase = PH_STOP_A;
                            end
                        endcase
                    end
                    PH_RX_LOW: s.phase = PH_RX_HIGH;
                    PH_RX_HIGH:
                    begin
                        s.shift     = rx_shift;
                        s.bit_index = bit_inc;
                        if (bit_inc >= BYTE_BITS)
                        begin
                            res.byte_valid = 1'b1;
                            res.read_byte  = rx_shift;
                            res.last_byte  = mack;
                            s.phase        = PH_MACK_LOW;
                        end
                        else
                        begin
                            s.phase = PH_RX_LOW;
                        end
                    end
                    PH_MACK_LOW: s.phase = PH_MACK_HIGH;
                    PH_MACK_HIGH:
                    begin
                        s.bytes_left = left_dec;
                        if (left_dec == 9'd0)
                        begin
                            s.stage = ST_END_STOP;
                            s.phase = PH_STOP_A;
                        end
                        else
                        begin
                            s.shift     = 8'd0;
                            s.bit_index = 4'd0;
                            s.phase     = PH_RX_LOW;
                        end
                    end
                    PH_STOP_A: s.phase = PH_STOP_B;
                    PH_STOP_B: s.phase = PH_STOP_C;
                    default:
                    begin
                        if (s.stage == ST_MID_STOP)
                        begin
                            s.stage = ST_ADDR_R;
                            s.phase = PH_START_A;
                        end
                        else
                        begin
                            res.done_res = 1'b1;
                            s.phase      = PH_IDLE;
                        end
                    end
                endcase
            end
        end

        res.nack_seen = s.nack_flag;
        st_next       = s;
    end

endmodule

[sv/i2c_register_master.sv]
// i2c register master top level: sequencer state, config registers, result register
// latency: a result word is registered and appears in the cycle after its command word is accepted
// throughput: one command word per cycle while the result register is free or being taken
// the tick logic between sequencer state and result register sets the cycle time
// reset: sequencer idle, device address 0, phase_ticks 5, no result pending
module i2c_register_master (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_wdata,
    i2crm_cmd_if.sink            cmd,
    i2crm_res_if.source          res
);
    import i2crm_pkg::*;

    seq_state_t  seq_reg;
    seq_state_t  seq_next;
    result_t     step_res;
    result_t     res_data_reg;
    logic        res_valid_reg;
    logic [6:0]  dev_addr_reg;
    logic [15:0] phase_ticks_reg;
    logic        accept;

    // tick logic
    i2crm_step u_step (
        .st             (seq_reg),
        .device_address (dev_addr_reg),
        .phase_ticks    (phase_ticks_reg),
        .op             (cmd.op),
        .reg_addr       (cmd.reg_addr),
        .write_data     (cmd.write_data),
        .read_count     (cmd.read_count),
        .sda_in         (cmd.sda_in),
        .st_next        (seq_next),
        .res            (step_res)
    );

    // take a word whenever the output register is free or being emptied
    assign cmd.ready = !res_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg    <= 7'd0;
            phase_ticks_reg <= 16'd5;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS: dev_addr_reg    <= cfg_wdata[6:0];
                CFG_PHASE_TICKS:    phase_ticks_reg <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= '{phase: PH_IDLE, stage: ST_ADDR_W, default: '0};
        end
        else if (accept)
        begin
            seq_reg <= seq_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_data_reg <= step_res;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.scl_out    = res_data_reg.scl_out;
    assign res.sda_out    = res_data_reg.sda_out;
    assign res.byte_valid = res_data_reg.byte_valid;
    assign res.read_byte  = res_data_reg.read_byte;
    assign res.last_byte  = res_data_reg.last_byte;
    assign res.nack_seen  = res_data_reg.nack_seen;
    assign res.busy_res   = res_data_reg.busy_res;
    assign res.done_res   = res_data_reg.done_res;

endmodule

[bench/i2crm_checker.sv]
`timescale 1ns / 1ps
// bus word predictor and scoreboard for the i2c register master
module i2crm_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    i2crm_cmd_if        cmd,
    i2crm_res_if        res,
    output int          fail_count,
    output int          pending,
    output logic        seq_idle,
    output int          words_checked,
    output int          transfers_done,
    output int          bytes_read,
    output int          nacked_transfers
);
    import i2crm_pkg::*;

    // shadow copy of the configuration
    logic [6:0]  dev_addr;
    logic [15:0] phase_len;

    // shadow copy of the sequencer
    phase_t      ph;
    stage_t      stg;
    logic [15:0] tcnt;
    logic [3:0]  bidx;
    logic [7:0]  shreg;
    logic [8:0]  left;
    logic [7:0]  hreg;
    logic [7:0]  hdata;
    logic        rd;
    logic        nack;

    // bus words still owed by the block, oldest first
    result_t expected_words[$];

    // one tick of the sequencer: returns the bus word it drives
    function automatic result_t advance_bus(logic [1:0] op, logic [7:0] ra, logic [7:0] wd,
                                            logic [8:0] rc, logic sda);
        result_t     r;
        logic [15:0] len;
        logic [8:0]  cnt;
        logic        txb;
        logic        mack;
        logic        fin;

        r = '0;
        r.scl_out = 1'b1;
        r.sda_out = 1'b1;
        len = (phase_len == 16'd0) ? 16'd1 : phase_len;

        // command taken only when idle, burst length clamped to 1..MAX_BURST
        if (ph == PH_IDLE && (op == OP_WRITE || op == OP_READ)) begin
            cnt = rc;
            if (cnt == 9'd0)
                cnt = 9'd1;
            if (cnt > BURST_MAX_VAL)
                cnt = BURST_MAX_VAL;
            hreg  = ra;
            hdata = wd;
            left  = cnt;
            rd    = (op == OP_READ);
            nack  = 1'b0;
            stg   = ST_ADDR_W;
            ph    = PH_START_A;
            tcnt  = '0;
        end

        if (ph != PH_IDLE) begin
            txb  = shreg[7];
            mack = (left == 9'd1);
            r.busy_res = 1'b1;

            // drive levels of the current phase
            case (ph)
                PH_START_A:               {r.scl_out, r.sda_out} = 2'b11;
                PH_START_B:               {r.scl_out, r.sda_out} = 2'b10;
                PH_START_C:               {r.scl_out, r.sda_out} = 2'b00;
                PH_TX_LOW:                {r.scl_out, r.sda_out} = {1'b0, txb};
                PH_TX_HIGH:               {r.scl_out, r.sda_out} = {1'b1, txb};
                PH_ACK_LOW, PH_RX_LOW:    {r.scl_out, r.sda_out} = 2'b01;
                PH_ACK_HIGH, PH_RX_HIGH:  {r.scl_out, r.sda_out} = 2'b11;
                PH_MACK_LOW:              {r.scl_out, r.sda_out} = {1'b0, mack};
                PH_MACK_HIGH:             {r.scl_out, r.sda_out} = {1'b1, mack};
                PH_STOP_A:                {r.scl_out, r.sda_out} = 2'b00;
                PH_STOP_B:                {r.scl_out, r.sda_out} = 2'b10;
                default:                  {r.scl_out, r.sda_out} = 2'b11;
            endcase

            tcnt = tcnt + 16'd1;
            fin  = (tcnt >= len) || (tcnt == 16'd0);

            // phase over: every transition restarts the tick count
            if (fin) begin
                tcnt = '0;
                case (ph)
                    PH_START_A: ph = PH_START_B;
                    PH_START_B: ph = PH_START_C;
                    PH_START_C:
                    begin
                        if (stg == ST_ADDR_R)
                            shreg = {dev_addr, 1'b1};
                        else
                        begin
                            stg   = ST_ADDR_W;
                            shreg = {dev_addr, 1'b0};
                        end
                        bidx = '0;
                        ph   = PH_TX_LOW;
                    end
                    PH_TX_LOW: ph = PH_TX_HIGH;
                    PH_TX_HIGH:
                    begin
                        shreg = shreg << 1;
                        bidx  = bidx + 4'd1;
                        ph    = (bidx >= BYTE_BITS) ? PH_ACK_LOW : PH_TX_LOW;
                    end
                    PH_ACK_LOW: ph = PH_ACK_HIGH;
                    PH_ACK_HIGH:
                    begin
                        if (sda)
                            nack = 1'b1;
                        case (stg)
                            ST_ADDR_W:
                            begin
                                stg   = ST_REG;
                                shreg = hreg;
                                bidx  = '0;
                                ph    = PH_TX_LOW;
                            end
                            ST_REG:
                            begin
                                if (rd)
                                begin
                                    stg = ST_MID_STOP;
                                    ph  = PH_STOP_A;
                                end
                                else
                                begin
                                    stg   = ST_DATA;
                                    shreg = hdata;
                                    bidx  = '0;
                                    ph    = PH_TX_LOW;
                                end
                            end
                            ST_ADDR_R:
                            begin
                                stg   = ST_RECV;
                                shreg = '0;
                                bidx  = '0;
                                ph    = PH_RX_LOW;
                            end
                            default:
                            begin
                                stg = ST_END_STOP;
                                ph  = PH_STOP_A;
                            end
                        endcase
                    end
                    PH_RX_LOW: ph = PH_RX_HIGH;
                    PH_RX_HIGH:
                    begin
                        shreg = {shreg[6:0], sda};
                        bidx  = bidx + 4'd1;
                        if (bidx >= BYTE_BITS)
                        begin
                            r.byte_valid = 1'b1;
                            r.read_byte  = shreg;
                            r.last_byte  = mack;
                            ph = PH_MACK_LOW;
                        end
                        else
                            ph = PH_RX_LOW;
                    end
                    PH_MACK_LOW: ph = PH_MACK_HIGH;
                    PH_MACK_HIGH:
                    begin
                        if (left != 9'd0)
                            left = left - 9'd1;
                        if (left == 9'd0)
                        begin
                            stg = ST_END_STOP;
                            ph  = PH_STOP_A;
                        end
                        else
                        begin
                            shreg = '0;
                            bidx  = '0;
                            ph    = PH_RX_LOW;
                        end
                    end
                    PH_STOP_A: ph = PH_STOP_B;
                    PH_STOP_B: ph = PH_STOP_C;
                    default:
                    begin
                        // a read restarts after the stop behind the register byte
                        if (stg == ST_MID_STOP)
                        begin
                            stg = ST_ADDR_R;
                            ph  = PH_START_A;
                        end
                        else
                        begin
                            r.done_res = 1'b1;
                            ph = PH_IDLE;
                        end
                    end
                endcase
            end
        end

        r.nack_seen = nack;
        return r;
    endfunction

    // one field of a bus word against its expectation
    task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", field, want, got);
            fail_count++;
        end
    endtask

    // config writes, result compare, then prediction of the new command word
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            dev_addr  = '0;
            phase_len = 16'd5;
            ph    = PH_IDLE;
            stg   = ST_ADDR_W;
            tcnt  = '0;
            bidx  = '0;
            shreg = '0;
            left  = '0;
            hreg  = '0;
            hdata = '0;
            rd    = 1'b0;
            nack  = 1'b0;
            expected_words.delete();
            fail_count       = 0;
            words_checked    = 0;
            transfers_done   = 0;
            bytes_read       = 0;
            nacked_transfers = 0;
            pending  <= 0;
            seq_idle <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_DEVICE_ADDRESS)
                    dev_addr = cfg_wdata[6:0];
                else if (cfg_index == CFG_PHASE_TICKS)
                    phase_len = cfg_wdata;
            end

            if (res.valid && res.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("bus word arrived with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("scl_out",    8'(want.scl_out),    8'(res.scl_out));
                    check_field("sda_out",    8'(want.sda_out),    8'(res.sda_out));
                    check_field("byte_valid", 8'(want.byte_valid), 8'(res.byte_valid));
                    check_field("read_byte",  want.read_byte,      res.read_byte);
                    check_field("last_byte",  8'(want.last_byte),  8'(res.last_byte));
                    check_field("nack_seen",  8'(want.nack_seen),  8'(res.nack_seen));
                    check_field("busy_res",   8'(want.busy_res),   8'(res.busy_res));
                    check_field("done_res",   8'(want.done_res),   8'(res.done_res));
                    words_checked++;
                    if (want.byte_valid)
                        bytes_read++;
                    if (want.done_res)
                    begin
                        transfers_done++;
                        if (want.nack_seen)
                            nacked_transfers++;
                    end
                end
            end

            if (cmd.valid && cmd.ready)
                expected_words.push_back(advance_bus(cmd.op, cmd.reg_addr, cmd.write_data,
                                                     cmd.read_count, cmd.sda_in));

            pending  <= expected_words.size();
            seq_idle <= (ph == PH_IDLE);
        end
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// top of the i2c register master bench: clock, reset, word traffic and verdict
module tb;
    import i2crm_pkg::*;

    localparam logic [1:0] OP_RESERVED = 2'd3;

    // how sda_in behaves during a directed transfer
    localparam int SDA_LOW    = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_RANDOM = 2;

    localparam int MAX_IDLE             = 12;
    localparam int LONG_HOLD            = 120;
    localparam int HOLD_EVERY           = 400;
    localparam int CALM_SPAN            = 40;
    localparam int BUSY_CMD_WORDS       = 8;
    localparam int WATCHDOG_LIMIT       = 1000;
    localparam int RANDOM_SESSION_WORDS = 40;
    localparam int DEFAULT_PHASE_WORDS  = 30;
    localparam int SLOW_PHASE_WORDS     = 30;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    int   fail_count;
    int   pending;
    logic seq_idle;
    int   words_checked;
    int   transfers_done;
    int   bytes_read;
    int   nacked_transfers;

    int quiet_cycles;
    int sent;
    int taken;
    bit fast;
    bit send_calm;
    bit take_calm;

    i2crm_cmd_if cmd_ch();
    i2crm_res_if res_ch();

    i2c_register_master u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    i2crm_checker u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .cmd              (cmd_ch),
        .res              (res_ch),
        .fail_count       (fail_count),
        .pending          (pending),
        .seq_idle         (seq_idle),
        .words_checked    (words_checked),
        .transfers_done   (transfers_done),
        .bytes_read       (bytes_read),
        .nacked_transfers (nacked_transfers)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // watchdog: too long with no word moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side: random stalls, calm stretches, a long hold now and then
    initial
    begin
        int wait_cycles;
        res_ch.ready = 1'b0;
        taken = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken % CALM_SPAN == 0)
                take_calm = ($urandom_range(0, 2) == 0);
            if (taken % HOLD_EVERY == HOLD_EVERY / 2)
                wait_cycles = LONG_HOLD;
            else if (fast || take_calm)
                wait_cycles = 0;
            else
                wait_cycles = $urandom_range(0, MAX_IDLE);
            if (wait_cycles > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            taken++;
        end
    end

    function automatic logic pick_sda(int mode);
        case (mode)
            SDA_LOW:  return 1'b0;
            SDA_HIGH: return 1'b1;
            default:  return 1'($urandom);
        endcase
    endfunction

    // offer one command word after a random gap and wait until it is taken
    task automatic send_word(logic [1:0] op, logic [7:0] ra, logic [7:0] wd,
                             logic [8:0] rc, logic sda);
        int gap;
        if (sent % CALM_SPAN == 0)
            send_calm = ($urandom_range(0, 2) == 0);
        gap = (fast || send_calm) ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.op         <= op;
        cmd_ch.reg_addr   <= ra;
        cmd_ch.write_data <= wd;
        cmd_ch.read_count <= rc;
        cmd_ch.sda_in     <= sda;
        do @(posedge clk); while (!cmd_ch.ready);
        sent++;
    endtask

    // start a command, then tick until the sequencer is idle again
    task automatic run_transfer(logic [1:0] op, logic [7:0] ra, logic [7:0] wd,
                                logic [8:0] rc, int sda_mode, logic [1:0] busy_op);
        int n;
        send_word(op, ra, wd, rc, pick_sda(sda_mode));
        n = 0;
        do
        begin
            // commands while busy only early on, so none lands after the stop
            send_word((n < BUSY_CMD_WORDS) ? busy_op : OP_TICK, 8'($urandom), 8'($urandom),
                      9'($urandom), pick_sda(sda_mode));
            n++;
        end
        while (!seq_idle);
    endtask

    // stop offering and wait until every owed bus word has been taken
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        @(posedge clk);
        cfg_index <= idx;
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        logic [1:0] op;
        logic [8:0] rc;
        int n;
        int phase_list[3];

        phase_list = '{1, 2, 1};
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_DEVICE_ADDRESS;
        cfg_wdata         = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.op         = OP_TICK;
        cmd_ch.reg_addr   = '0;
        cmd_ch.write_data = '0;
        cmd_ch.read_count = '0;
        cmd_ch.sda_in     = 1'b1;
        fast = 1'b0;
        sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // idle ticks, plain and with the unused op code
        send_word(OP_TICK, 8'h00, 8'h00, 9'd0, 1'b1);
        send_word(OP_RESERVED, 8'hFF, 8'hFF, 9'h1FF, 1'b0);

        // reset defaults: address 0, five ticks per phase, through start into the address
        send_word(OP_WRITE, 8'hFF, 8'h00, 9'd1, 1'b0);
        repeat (DEFAULT_PHASE_WORDS) send_word(OP_TICK, 8'($urandom), 8'($urandom),
                                               9'($urandom), 1'b0);
        // finish that write at the shortest phase, every byte acked
        settle();
        write_reg(CFG_PHASE_TICKS, 16'd1);
        do
            send_word(OP_TICK, 8'($urandom), 8'($urandom), 9'($urandom), 1'b0);
        while (!seq_idle);

        // top address, shortest phase, no ack on the first and last transfers
        settle();
        write_reg(CFG_PHASE_TICKS, 16'd1);
        write_reg(CFG_DEVICE_ADDRESS, {9'h1FF, 7'h7F});
        run_transfer(OP_WRITE, 8'h00, 8'hFF, 9'h1FF, SDA_HIGH, OP_RESERVED);
        // zero count becomes one byte, commands during the transfer are ignored
        run_transfer(OP_READ, 8'h5A, 8'hA5, 9'd0, SDA_RANDOM, OP_WRITE);
        run_transfer(OP_READ, 8'h81, 8'h7E, 9'd2, SDA_HIGH, OP_READ);

        // zero phase length acts as one tick
        settle();
        write_reg(CFG_PHASE_TICKS, 16'd0);
        write_reg(CFG_DEVICE_ADDRESS, 16'd0);
        run_transfer(OP_READ, 8'h24, 8'hDB, 9'd3, SDA_LOW, OP_TICK);

        // longest phase: run part of a start phase, then shorten mid-transfer
        settle();
        write_reg(CFG_PHASE_TICKS, 16'hFFFF);
        write_reg(CFG_DEVICE_ADDRESS, 16'($urandom));
        fast = 1'b1;
        send_word(OP_WRITE, 8'($urandom), 8'($urandom), 9'd1, 1'b0);
        repeat (SLOW_PHASE_WORDS) send_word(OP_TICK, 8'($urandom), 8'($urandom),
                                            9'($urandom), 1'b0);
        settle();
        write_reg(CFG_PHASE_TICKS, 16'd2);
        do
            send_word(OP_TICK, 8'($urandom), 8'($urandom), 9'($urandom), 1'($urandom));
        while (!seq_idle);
        fast = 1'b0;

        // random sessions: commands at random while idle, noise while busy
        foreach (phase_list[s])
        begin
            settle();
            write_reg(CFG_PHASE_TICKS, 16'(phase_list[s]));
            write_reg(CFG_DEVICE_ADDRESS, 16'($urandom));
            n = 0;
            while (n < RANDOM_SESSION_WORDS || !seq_idle)
            begin
                if (n < RANDOM_SESSION_WORDS && seq_idle && $urandom_range(0, 1) == 1)
                begin
                    op = ($urandom_range(0, 1) == 1) ? OP_READ : OP_WRITE;
                    rc = ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 4));
                end
                else
                begin
                    op = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : OP_TICK;
                    rc = 9'($urandom);
                end
                send_word(op, 8'($urandom), 8'($urandom), rc, 1'($urandom));
                n++;
            end
        end

        settle();
        $display("run covered %0d bus words, %0d finished transfers, %0d bytes read back",
                 words_checked, transfers_done, bytes_read);
        $display("%0d transfers saw a missing ack; phase lengths 0 to 65535 exercised",
                 nacked_transfers);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[i2c_register_master.f]
sv/i2crm_pkg.sv
sv/i2crm_if.sv
sv/i2crm_step.sv
sv/i2c_register_master.sv
bench/i2crm_checker.sv
bench/tb.sv
